>>> hw/rtl/ofr_pkg.sv
package ofr_pkg;

    localparam int RX_CAPACITY = 128;

    localparam logic [7:0]  SYNC_BYTE  = 8'h55;
    localparam logic [7:0]  CRC_POLY   = 8'h07;
    localparam logic [15:0] SFLOAT_NAN = 16'h07FF;
    localparam logic [16:0] POS_MAX    = 17'h1FFFF;
    localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
    localparam logic [16:0] MIN_FRAME_LEN  = 17'd9;
    localparam logic [15:0] MIN_PAYLOAD    = 16'd12;
    localparam logic [7:0]  SPO2_MAX   = 8'd100;
    localparam logic [15:0] PULSE_LIMIT = 16'd250;

    typedef enum logic [1:0] {
        OP_BYTE      = 2'd0,
        OP_READ_CMD  = 2'd1,
        OP_OTHER_CMD = 2'd2,
        OP_TIMEOUT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_IGNORED = 2'd0,
        STATUS_FAILED  = 2'd1,
        STATUS_DECODED = 2'd2
    } status_t;

    // decoder state seen at the end of a chunk
    typedef struct packed {
        logic [16:0] pos;
        logic [31:0] header;
        logic        header_ok;
        logic        crc_match;
        logic [48:0] capture;
    } dec_state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  spo2_percent;
        logic [15:0] pulse_rate;
        logic [7:0]  battery_level;
        logic [7:0]  battery_status;
        logic [7:0]  perfusion_index;
        logic        lead_flag;
        logic [15:0] spo2_sfloat;
        logic [15:0] pulse_sfloat;
        logic        reading_invalid;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/ofr_decode.sv
module ofr_decode (
    input  ofr_pkg::dec_state_t dec,
    input  logic                read_pending,
    output ofr_pkg::result_t    result
);

    logic [16:0] frame_len;
    logic        frame_ok;
    logic [7:0]  spo2;
    logic [15:0] pulse;
    logic        reading_valid;

    assign frame_len = {1'b0, dec.header[31:16]} + ofr_pkg::FRAME_OVERHEAD;
    assign frame_ok  = (dec.pos >= ofr_pkg::MIN_FRAME_LEN) && dec.header_ok
                     && (dec.header[31:16] >= ofr_pkg::MIN_PAYLOAD)
                     && (dec.pos >= frame_len) && dec.crc_match;

    assign spo2  = dec.capture[7:0];
    assign pulse = dec.capture[23:8];
    assign reading_valid = (spo2 != 8'd0) && (spo2 <= ofr_pkg::SPO2_MAX)
                         && (pulse != 16'd0) && (pulse < ofr_pkg::PULSE_LIMIT);

    always_comb
    begin
        result                 = '0;
        result.status          = ofr_pkg::STATUS_IGNORED;
        result.spo2_sfloat     = ofr_pkg::SFLOAT_NAN;
        result.pulse_sfloat    = ofr_pkg::SFLOAT_NAN;
        result.reading_invalid = 1'b1;
        if (read_pending)
        begin
            if (!frame_ok)
            begin
                result.status = ofr_pkg::STATUS_FAILED;
            end
            else
            begin
                result.status          = ofr_pkg::STATUS_DECODED;
                result.spo2_percent    = spo2;
                result.pulse_rate      = pulse;
                result.battery_level   = dec.capture[31:24];
                result.battery_status  = dec.capture[39:32];
                result.perfusion_index = dec.capture[47:40];
                result.lead_flag       = dec.capture[48];
                if (reading_valid)
                begin
                    result.spo2_sfloat     = {8'd0, spo2};
                    result.pulse_sfloat    = pulse;
                    result.reading_invalid = 1'b0;
                end
            end
        end
    end

endmodule

>>> hw/rtl/oximeter_frame_receiver.sv
// Pulse-oximeter notification frame receiver.
// Input stream: one item per received byte or event. s_axis_tuser[1:0] is the
// operation (byte, read command sent, other command sent, response timeout),
// s_axis_tuser[2] marks the first byte of a notification chunk, s_axis_tlast
// the last one, and s_axis_tdata carries the byte.
// Output stream: at most one item per chunk end, only when a frame is complete
// or the chunk stands alone. m_axis_tuser is the status (ignored, failed,
// decoded), m_axis_tdata the reading fields.
// One input item per cycle is taken while the sink accepts results. Each item
// is held in the input register; the running CRC, header and field capture
// update from it at the edge that also loads the output register. A result
// therefore passes the input register and then the output register.
// Frames of up to 128 bytes are assembled across chunks; an assembly that runs
// past 128 bytes is dropped silently with the rest of its chunk.
// When the sink holds m_axis_tready low, the result stays in the output
// register, one more item waits in the input register, and then
// s_axis_tready falls until the result is taken.
// Reset clears all pending commands, the assembly and both valid flags.
module oximeter_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [2:0]  s_axis_tuser,   // operation[1:0], chunk_first
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // spo2_percent, pulse_rate, battery_level, battery_status, perfusion_index,
    // lead_flag, spo2_sfloat, pulse_sfloat, reading_invalid, zero pad
    output logic [87:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // status
);

    logic                in_valid_reg;
    ofr_pkg::op_t        in_op_reg;
    logic [7:0]          in_byte_reg;
    logic                in_first_reg;
    logic                in_last_reg;

    logic                read_pending_reg, read_pending_next;
    logic                cmd_pending_reg, cmd_pending_next;
    logic [16:0]         frame_want_reg, frame_want_next;
    logic [16:0]         frame_count_reg, frame_count_next;
    logic [2:0]          chunk_count_reg, chunk_count_next;
    logic                lead_sync_reg, lead_sync_next;
    logic                chunk_drop_reg, chunk_drop_next;
    logic [16:0]         pos_reg, pos_next;
    logic [7:0]          crc_reg, crc_next;
    logic [31:0]         header_reg, header_next;
    logic                header_ok_reg, header_ok_next;
    logic                crc_match_reg, crc_match_next;
    logic [48:0]         capture_reg, capture_next;

    logic                out_valid_reg;
    ofr_pkg::result_t    out_result_reg;

    logic                advance;
    logic                emit;
    logic                sync_hit;
    logic                open_chunk;
    logic [16:0]         frame_len;
    ofr_pkg::dec_state_t dec_state;
    ofr_pkg::result_t    dec_result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign sync_hit      = (in_byte_reg == ofr_pkg::SYNC_BYTE);
    assign open_chunk    = in_first_reg || (chunk_count_reg == 3'd0);

    always_comb
    begin
        read_pending_next = read_pending_reg;
        cmd_pending_next  = cmd_pending_reg;
        frame_want_next   = frame_want_reg;
        frame_count_next  = frame_count_reg;
        chunk_count_next  = chunk_count_reg;
        lead_sync_next    = lead_sync_reg;
        chunk_drop_next   = chunk_drop_reg;
        pos_next          = pos_reg;
        crc_next          = crc_reg;
        header_next       = header_reg;
        header_ok_next    = header_ok_reg;
        crc_match_next    = crc_match_reg;
        capture_next      = capture_reg;
        frame_len         = 17'd0;
        emit              = 1'b0;
        if (advance)
        begin
            case (in_op_reg)
                ofr_pkg::OP_READ_CMD:
                begin
                    read_pending_next = 1'b1;
                    cmd_pending_next  = 1'b1;
                end
                ofr_pkg::OP_OTHER_CMD:
                begin
                    read_pending_next = 1'b0;
                    cmd_pending_next  = 1'b1;
                end
                ofr_pkg::OP_TIMEOUT:
                begin
                    if (cmd_pending_reg)
                    begin
                        read_pending_next = 1'b0;
                        cmd_pending_next  = 1'b0;
                        frame_want_next   = 17'd0;
                        frame_count_next  = 17'd0;
                        chunk_drop_next   = 1'b1;
                    end
                end
                ofr_pkg::OP_BYTE:
                begin
                    if (open_chunk)
                    begin
                        chunk_count_next = 3'd0;
                        chunk_drop_next  = 1'b0;
                        lead_sync_next   = sync_hit;
                        if (sync_hit)
                        begin
                            frame_want_next  = 17'd0;
                            frame_count_next = 17'd0;
                        end
                        if (frame_want_next == 17'd0)
                        begin
                            pos_next       = 17'd0;
                            crc_next       = 8'd0;
                            header_next    = 32'd0;
                            header_ok_next = 1'b0;
                            crc_match_next = 1'b0;
                            capture_next   = 49'd0;
                        end
                    end

                    if (!chunk_drop_next)
                    begin
                        // header capture and checks
                        if (pos_next == 17'd0)
                        begin
                            header_ok_next = sync_hit;
                        end
                        if (pos_next == 17'd1)
                        begin
                            header_next[7:0] = in_byte_reg;
                        end
                        if (pos_next == 17'd2)
                        begin
                            header_next[15:8] = in_byte_reg;
                            if (header_next[7:0] != ~in_byte_reg)
                            begin
                                header_ok_next = 1'b0;
                            end
                        end
                        if (pos_next == 17'd5)
                        begin
                            header_next[23:16] = in_byte_reg;
                        end
                        if (pos_next == 17'd6)
                        begin
                            header_next[31:24] = in_byte_reg;
                        end

                        frame_len = {1'b0, header_next[31:16]} + ofr_pkg::FRAME_OVERHEAD;
                        if (pos_next < 17'd7)
                        begin
                            crc_next = ofr_pkg::crc8_update(crc_next, in_byte_reg);
                        end
                        else
                        begin
                            if (pos_next < frame_len - 17'd1)
                            begin
                                crc_next = ofr_pkg::crc8_update(crc_next, in_byte_reg);
                            end
                            else if (pos_next == frame_len - 17'd1)
                            begin
                                crc_match_next = (crc_next == in_byte_reg);
                            end
                            // payload field capture
                            case (pos_next)
                                17'd7:   capture_next[7:0]   = in_byte_reg;
                                17'd8:   capture_next[15:8]  = in_byte_reg;
                                17'd9:   capture_next[23:16] = in_byte_reg;
                                17'd14:  capture_next[31:24] = in_byte_reg;
                                17'd15:  capture_next[39:32] = in_byte_reg;
                                17'd17:  capture_next[47:40] = in_byte_reg;
                                17'd18:  capture_next[48]    = in_byte_reg[0];
                                default: ;
                            endcase
                        end
                        if (pos_next != ofr_pkg::POS_MAX)
                        begin
                            pos_next = pos_next + 17'd1;
                        end

                        // assembly bookkeeping
                        if (lead_sync_next || (frame_want_next != 17'd0))
                        begin
                            if (frame_count_next != ofr_pkg::POS_MAX)
                            begin
                                frame_count_next = frame_count_next + 17'd1;
                            end
                        end
                        if (lead_sync_next && (chunk_count_next == 3'd6))
                        begin
                            if (frame_len <= 17'(ofr_pkg::RX_CAPACITY))
                            begin
                                frame_want_next = frame_len;
                            end
                        end
                        if ((frame_want_next != 17'd0)
                            && (frame_count_next > 17'(ofr_pkg::RX_CAPACITY)))
                        begin
                            frame_want_next  = 17'd0;
                            frame_count_next = 17'd0;
                            chunk_drop_next  = 1'b1;
                        end
                    end
                    if (chunk_count_next != 3'd7)
                    begin
                        chunk_count_next = chunk_count_next + 3'd1;
                    end

                    if (in_last_reg)
                    begin
                        chunk_count_next = 3'd0;
                        if (!chunk_drop_next
                            && !((frame_want_next != 17'd0)
                                 && (frame_count_next < frame_want_next)))
                        begin
                            emit              = 1'b1;
                            read_pending_next = 1'b0;
                            cmd_pending_next  = 1'b0;
                            frame_want_next   = 17'd0;
                            frame_count_next  = 17'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        dec_state.pos       = pos_next;
        dec_state.header    = header_next;
        dec_state.header_ok = header_ok_next;
        dec_state.crc_match = crc_match_next;
        dec_state.capture   = capture_next;
    end

    ofr_decode u_decode (
        .dec          (dec_state),
        .read_pending (read_pending_reg),
        .result       (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            read_pending_reg <= 1'b0;
            cmd_pending_reg  <= 1'b0;
            frame_want_reg   <= 17'd0;
            frame_count_reg  <= 17'd0;
            chunk_count_reg  <= 3'd0;
            lead_sync_reg    <= 1'b0;
            chunk_drop_reg   <= 1'b0;
            pos_reg          <= 17'd0;
            crc_reg          <= 8'd0;
            header_reg       <= 32'd0;
            header_ok_reg    <= 1'b0;
            crc_match_reg    <= 1'b0;
            capture_reg      <= 49'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            read_pending_reg <= read_pending_next;
            cmd_pending_reg  <= cmd_pending_next;
            frame_want_reg   <= frame_want_next;
            frame_count_reg  <= frame_count_next;
            chunk_count_reg  <= chunk_count_next;
            lead_sync_reg    <= lead_sync_next;
            chunk_drop_reg   <= chunk_drop_next;
            pos_reg          <= pos_next;
            crc_reg          <= crc_next;
            header_reg       <= header_next;
            header_ok_reg    <= header_ok_next;
            crc_match_reg    <= crc_match_next;
            capture_reg      <= capture_next;

            if (advance)
            begin
                out_valid_reg <= emit;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_op_reg    <= ofr_pkg::op_t'(s_axis_tuser[1:0]);
            in_first_reg <= s_axis_tuser[2];
            in_byte_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
        end
        if (emit)
        begin
            out_result_reg <= dec_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.status;
    assign m_axis_tdata  = {6'd0,
                            out_result_reg.reading_invalid,
                            out_result_reg.pulse_sfloat,
                            out_result_reg.spo2_sfloat,
                            out_result_reg.lead_flag,
                            out_result_reg.perfusion_index,
                            out_result_reg.battery_status,
                            out_result_reg.battery_level,
                            out_result_reg.pulse_rate,
                            out_result_reg.spo2_percent};

`ifndef ASSERT_OFF
    // an active assembly never exceeds the receive capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_want_reg != 17'd0) |-> ((frame_want_reg >= ofr_pkg::FRAME_OVERHEAD)
            && (frame_want_reg <= 17'(ofr_pkg::RX_CAPACITY))
            && (frame_count_reg <= 17'(ofr_pkg::RX_CAPACITY))))
        else $error("assembly beyond receive capacity");

    // a result that is not a decoded reading carries the invalid marks
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ofr_pkg::STATUS_DECODED))
            |-> (m_axis_tdata[81] && (m_axis_tdata[64:49] == ofr_pkg::SFLOAT_NAN)))
        else $error("failed result without invalid marks");

    // input stalls only while an item is held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a held item");

    // a result is only produced for a byte that closes a chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (in_valid_reg && in_last_reg && (in_op_reg == ofr_pkg::OP_BYTE)))
        else $error("result outside a chunk end");

    // an emitted result clears the pending commands
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (!read_pending_reg && !cmd_pending_reg))
        else $error("pending command kept after result");
`endif

endmodule

>>> tb/sv/oximeter_frame_checker.sv
module oximeter_frame_checker
    import ofr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [2:0]  s_axis_tuser,   // operation[1:0], chunk_first
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // spo2_percent, pulse_rate, battery_level, battery_status, perfusion_index,
    // lead_flag, spo2_sfloat, pulse_sfloat, reading_invalid, zero pad
    input  logic [87:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,   // status
    output int          fail_count,
    output int          pending_readings
);

    logic        read_armed;
    logic        cmd_out;
    logic [16:0] want_len;
    logic [16:0] asm_count;
    logic [2:0]  chunk_bytes;
    logic        sync_lead;
    logic        skip_chunk;
    logic [16:0] dec_pos;
    logic [7:0]  crc_acc;
    logic [31:0] hdr;
    logic        hdr_ok;
    logic        crc_ok;
    logic [48:0] capture;

    result_t expected_readings[$];
    int      mismatches;

    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic restart_decoder();
        dec_pos = '0;
        crc_acc = '0;
        hdr     = '0;
        hdr_ok  = 1'b0;
        crc_ok  = 1'b0;
        capture = '0;
    endtask

    task automatic drop_assembly();
        want_len  = '0;
        asm_count = '0;
    endtask

    task automatic reset_state();
        read_armed  = 1'b0;
        cmd_out     = 1'b0;
        chunk_bytes = '0;
        sync_lead   = 1'b0;
        skip_chunk  = 1'b0;
        drop_assembly();
        restart_decoder();
    endtask

    task automatic feed_decoder(input logic [7:0] b);
        int unsigned p;
        int unsigned flen;
        p = dec_pos;
        if (p == 0)
        begin
            hdr_ok = (b == SYNC_BYTE);
        end
        if (p == 1)
        begin
            hdr[7:0] |= b;
        end
        if (p == 2)
        begin
            hdr[15:8] |= b;
            if (hdr[7:0] != ~b)
            begin
                hdr_ok = 1'b0;
            end
        end
        if (p == 5)
        begin
            hdr[23:16] |= b;
        end
        if (p == 6)
        begin
            hdr[31:24] |= b;
        end
        if (p < 7)
        begin
            crc_acc = crc_step(crc_acc, b);
        end
        else
        begin
            flen = int'(hdr[31:16]) + 8;
            if (p < flen - 1)
            begin
                crc_acc = crc_step(crc_acc, b);
            end
            else if (p == flen - 1)
            begin
                crc_ok = (crc_acc == b);
            end
            case (p)
                7:  capture[7:0]   |= b;
                8:  capture[15:8]  |= b;
                9:  capture[23:16] |= b;
                14: capture[31:24] |= b;
                15: capture[39:32] |= b;
                17: capture[47:40] |= b;
                18: capture[48]    |= b[0];
                default: ;
            endcase
        end
        if (dec_pos < POS_MAX)
        begin
            dec_pos++;
        end
    endtask

    function automatic result_t decode_reading();
        result_t     r;
        int unsigned flen;
        logic        good;
        logic [7:0]  spo2;
        logic [15:0] pulse;
        flen = int'(hdr[31:16]) + 8;
        good = dec_pos >= MIN_FRAME_LEN && hdr_ok && hdr[31:16] >= MIN_PAYLOAD &&
               dec_pos >= flen && crc_ok;
        r = '0;
        r.spo2_sfloat     = SFLOAT_NAN;
        r.pulse_sfloat    = SFLOAT_NAN;
        r.reading_invalid = 1'b1;
        if (!read_armed)
        begin
            r.status = STATUS_IGNORED;
        end
        else if (!good)
        begin
            r.status = STATUS_FAILED;
        end
        else
        begin
            spo2  = capture[7:0];
            pulse = capture[23:8];
            r.status          = STATUS_DECODED;
            r.spo2_percent    = spo2;
            r.pulse_rate      = pulse;
            r.battery_level   = capture[31:24];
            r.battery_status  = capture[39:32];
            r.perfusion_index = capture[47:40];
            r.lead_flag       = capture[48];
            if (spo2 != 0 && spo2 != 8'hff && spo2 <= SPO2_MAX &&
                pulse != 0 && pulse != 16'h00ff && pulse < PULSE_LIMIT)
            begin
                r.spo2_sfloat     = {8'h00, spo2};
                r.pulse_sfloat    = pulse;
                r.reading_invalid = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic track_rx_item(input op_t op, input logic [7:0] b, input logic first,
                                 input logic last);
        int unsigned wanted;
        if (op == OP_READ_CMD)
        begin
            read_armed = 1'b1;
            cmd_out    = 1'b1;
        end
        else if (op == OP_OTHER_CMD)
        begin
            read_armed = 1'b0;
            cmd_out    = 1'b1;
        end
        else if (op == OP_TIMEOUT)
        begin
            if (cmd_out)
            begin
                read_armed = 1'b0;
                cmd_out    = 1'b0;
                drop_assembly();
                skip_chunk = 1'b1;
            end
        end
        else
        begin
            if (first || chunk_bytes == 0)
            begin
                chunk_bytes = '0;
                skip_chunk  = 1'b0;
                if (b == SYNC_BYTE)
                begin
                    drop_assembly();
                    sync_lead = 1'b1;
                    restart_decoder();
                end
                else
                begin
                    sync_lead = 1'b0;
                    if (want_len == 0)
                    begin
                        restart_decoder();
                    end
                end
            end
            if (!skip_chunk)
            begin
                feed_decoder(b);
                if ((sync_lead || want_len != 0) && asm_count < POS_MAX)
                begin
                    asm_count++;
                end
                if (sync_lead && chunk_bytes == 6)
                begin
                    wanted = int'(hdr[31:16]) + 8;
                    if (wanted <= RX_CAPACITY)
                    begin
                        want_len = wanted[16:0];
                    end
                end
                if (want_len != 0 && asm_count > RX_CAPACITY)
                begin
                    drop_assembly();
                    skip_chunk = 1'b1;
                end
            end
            if (chunk_bytes < 7)
            begin
                chunk_bytes++;
            end
            if (last)
            begin
                chunk_bytes = '0;
                // a frame still short of its length waits for more chunks
                if (!skip_chunk && !(want_len != 0 && asm_count < want_len))
                begin
                    expected_readings.push_back(decode_reading());
                    read_armed = 1'b0;
                    cmd_out    = 1'b0;
                    if (want_len != 0)
                    begin
                        drop_assembly();
                    end
                end
            end
        end
    endtask

    function automatic string reading_text(input result_t r);
        return $sformatf("status=%0d spo2=%0d pulse=%0d batt=%0d/%0d pi=%0d lead=%0d sf=%h/%h inv=%0d",
                         r.status, r.spo2_percent, r.pulse_rate, r.battery_level,
                         r.battery_status, r.perfusion_index, r.lead_flag, r.spo2_sfloat,
                         r.pulse_sfloat, r.reading_invalid);
    endfunction

    task automatic check_reading(input logic [1:0] code, input logic [87:0] d);
        result_t seen;
        result_t want;
        seen.status          = status_t'(code);
        seen.spo2_percent    = d[7:0];
        seen.pulse_rate      = d[23:8];
        seen.battery_level   = d[31:24];
        seen.battery_status  = d[39:32];
        seen.perfusion_index = d[47:40];
        seen.lead_flag       = d[48];
        seen.spo2_sfloat     = d[64:49];
        seen.pulse_sfloat    = d[80:65];
        seen.reading_invalid = d[81];
        if (expected_readings.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected reading: %s", reading_text(seen));
            end
        end
        else
        begin
            want = expected_readings.pop_front();
            if (seen.status != want.status || seen.spo2_percent != want.spo2_percent ||
                seen.pulse_rate != want.pulse_rate ||
                seen.battery_level != want.battery_level ||
                seen.battery_status != want.battery_status ||
                seen.perfusion_index != want.perfusion_index ||
                seen.lead_flag != want.lead_flag || seen.spo2_sfloat != want.spo2_sfloat ||
                seen.pulse_sfloat != want.pulse_sfloat ||
                seen.reading_invalid != want.reading_invalid)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("reading mismatch: expected %s, got %s",
                             reading_text(want), reading_text(seen));
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_state();
            expected_readings.delete();
            mismatches = 0;
            fail_count       <= 0;
            pending_readings <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_reading(m_axis_tuser, m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_rx_item(op_t'(s_axis_tuser[1:0]), s_axis_tdata, s_axis_tuser[2],
                              s_axis_tlast);
            end
            fail_count       <= mismatches;
            pending_readings <= expected_readings.size();
        end
    end

endmodule

>>> tb/sv/oximeter_frame_receiver_tb.sv
module oximeter_frame_receiver_tb;
    import ofr_pkg::*;

    localparam int ITEM_TARGET   = 900;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int pending_readings;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    logic [7:0] frame_bytes[$];

    oximeter_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    oximeter_frame_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .s_axis_tlast     (s_axis_tlast),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .fail_count       (fail_count),
        .pending_readings (pending_readings)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("oximeter_frame_receiver test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(input op_t op, input logic [7:0] b, input logic first,
                             input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {first, op};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // data and chunk marks mean nothing for events, so they are left random
    task automatic push_event(input op_t op);
        push_item(op, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic build_frame(input int plen, input logic [7:0] spo2, input logic [15:0] pulse);
        logic [7:0] cmd;
        logic [7:0] crc;
        cmd = 8'($urandom);
        frame_bytes.delete();
        frame_bytes.push_back(SYNC_BYTE);
        frame_bytes.push_back(cmd);
        frame_bytes.push_back(~cmd);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(plen[7:0]);
        frame_bytes.push_back(plen[15:8]);
        repeat (plen)
        begin
            frame_bytes.push_back(8'($urandom));
        end
        if (plen >= 3)
        begin
            frame_bytes[7] = spo2;
            frame_bytes[8] = pulse[7:0];
            frame_bytes[9] = pulse[15:8];
        end
        crc = 8'h00;
        foreach (frame_bytes[i])
        begin
            crc = crc8_update(crc, frame_bytes[i]);
        end
        frame_bytes.push_back(crc);
    endtask

    task automatic send_frame(input int max_chunk);
        int   idx;
        int   len;
        logic first;
        logic last;
        idx = 0;
        while (idx < frame_bytes.size())
        begin
            len = $urandom_range(max_chunk, 1);
            if (idx == 0 && len < 7 && $urandom_range(9) != 0)
            begin
                len = 7;
            end
            if (len > frame_bytes.size() - idx)
            begin
                len = frame_bytes.size() - idx;
            end
            for (int k = 0; k < len; k++)
            begin
                // missing first marks, reopened chunks and missing last marks now and then
                if (k == 0)
                begin
                    first = (idx == 0) || ($urandom_range(9) != 0);
                end
                else
                begin
                    first = ($urandom_range(49) == 0);
                end
                last = (k == len - 1) && ($urandom_range(19) != 0);
                if ($urandom_range(99) == 0)
                begin
                    push_event(op_t'($urandom_range(3, 1)));
                end
                push_item(OP_BYTE, frame_bytes[idx + k], first, last);
            end
            idx += len;
        end
    endtask

    task automatic run_transaction();
        int         pick;
        int         plen;
        int         n;
        int         chunk;
        logic       overflow;
        logic [7:0] spo2;
        logic [15:0] pulse;
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            push_event(OP_READ_CMD);
        end
        else if (pick < 85)
        begin
            push_event(OP_OTHER_CMD);
        end
        pick = $urandom_range(99);
        if (pick >= 88)
        begin
            n = $urandom_range(6, 1);
            repeat (n)
            begin
                if ($urandom_range(4) == 0)
                begin
                    push_event(op_t'($urandom_range(3, 1)));
                end
                else
                begin
                    push_item(OP_BYTE, ($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom),
                              1'($urandom), 1'($urandom));
                end
            end
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                plen = $urandom_range(24, 12);
            end
            else if (pick < 88)
            begin
                plen = $urandom_range(11, 0);
            end
            else if (pick < 96)
            begin
                plen = $urandom_range(120, 25);
            end
            else
            begin
                plen = $urandom_range(125, 121);
            end
            spo2  = ($urandom_range(4) != 0) ? 8'($urandom_range(101)) : 8'($urandom);
            pulse = ($urandom_range(4) != 0) ? 16'($urandom_range(255)) : 16'($urandom);
            build_frame(plen, spo2, pulse);
            n = $urandom_range(3);
            chunk = (n == 0) ? 7 : (n == 3) ? 64 : 20;
            overflow = 1'b0;
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                n = $urandom_range(frame_bytes.size() - 1);
                frame_bytes[n] = frame_bytes[n] ^ 8'($urandom_range(255, 1));
            end
            else if (pick < 18)
            begin
                repeat ($urandom_range(frame_bytes.size() - 1, 1))
                begin
                    void'(frame_bytes.pop_back());
                end
            end
            else if (pick < 22 && plen >= 12 && plen <= 24)
            begin
                // a long tail running past the assembly capacity, in chunks of up to 256 bytes
                overflow = 1'b1;
                repeat (RX_CAPACITY + 1 - frame_bytes.size() + $urandom_range(4))
                begin
                    frame_bytes.push_back(8'($urandom));
                end
            end
            send_frame(overflow ? 256 : chunk);
        end
    endtask

    task automatic await_readings();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_readings != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_event(OP_TIMEOUT);
        push_event(OP_OTHER_CMD);
        push_item(OP_BYTE, 8'h00, 1'b1, 1'b1);
        push_event(OP_READ_CMD);
        push_event(OP_TIMEOUT);
        push_item(OP_BYTE, SYNC_BYTE, 1'b1, 1'b1);
        push_event(OP_READ_CMD);
        build_frame(12, SPO2_MAX, PULSE_LIMIT - 16'd1);
        send_frame(20);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 86;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 86;
                end
                default:
                begin
                    idle_pct  = 18;
                    stall_pct = 18;
                end
            endcase
            while (items_sent < (phase + 1) * ITEM_TARGET / 4)
            begin
                run_transaction();
            end
            await_readings();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_readings == 0)
        begin
            $display("oximeter_frame_receiver test passed");
        end
        else
        begin
            $display("oximeter_frame_receiver test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ofr_pkg.sv
hw/rtl/ofr_decode.sv
hw/rtl/oximeter_frame_receiver.sv
tb/sv/oximeter_frame_checker.sv
tb/sv/oximeter_frame_receiver_tb.sv
